@@ src/c_lex_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer package
// Shared constants, scan states, token codes, word types and helper
// functions for the C-minus lexer.
// ----------------------------------------------------------------------------
package c_lex_pkg;

    // Lexeme storage. Lengths travel in a 5-bit field, so at most 31 bytes.
    localparam int LEXEME_CHARS = 31;
    localparam int CNT_W        = 5;
    localparam int LEX_BYTES    = 32;
    localparam int LEX_W        = LEX_BYTES * 8;

    // Token queue between front and back. Depth is a power of two.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Input word opcodes.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // Token codes.
    localparam logic [4:0] TK_ENDFILE = 5'd0;
    localparam logic [4:0] TK_ERROR   = 5'd1;
    localparam logic [4:0] TK_IF      = 5'd2;
    localparam logic [4:0] TK_ELSE    = 5'd3;
    localparam logic [4:0] TK_INT     = 5'd4;
    localparam logic [4:0] TK_RETURN  = 5'd5;
    localparam logic [4:0] TK_VOID    = 5'd6;
    localparam logic [4:0] TK_WHILE   = 5'd7;
    localparam logic [4:0] TK_ID      = 5'd8;
    localparam logic [4:0] TK_NUM     = 5'd9;
    localparam logic [4:0] TK_PLUS    = 5'd10;
    localparam logic [4:0] TK_MINUS   = 5'd11;
    localparam logic [4:0] TK_TIMES   = 5'd12;
    localparam logic [4:0] TK_DIV     = 5'd13;
    localparam logic [4:0] TK_GT      = 5'd14;
    localparam logic [4:0] TK_GE      = 5'd15;
    localparam logic [4:0] TK_LT      = 5'd16;
    localparam logic [4:0] TK_LE      = 5'd17;
    localparam logic [4:0] TK_EQ      = 5'd18;
    localparam logic [4:0] TK_NE      = 5'd19;
    localparam logic [4:0] TK_ASSIGN  = 5'd20;
    localparam logic [4:0] TK_SEMI    = 5'd21;
    localparam logic [4:0] TK_COMMA   = 5'd22;
    localparam logic [4:0] TK_LPAREN  = 5'd23;
    localparam logic [4:0] TK_RPAREN  = 5'd24;
    localparam logic [4:0] TK_LBRACK  = 5'd25;
    localparam logic [4:0] TK_RBRACK  = 5'd26;
    localparam logic [4:0] TK_LBRACE  = 5'd27;
    localparam logic [4:0] TK_RBRACE  = 5'd28;

    // Keywords, packed with the first character in the lowest byte
    // (so the literals read back to front) and zero padded.
    localparam int KW_COUNT = 6;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("fi"), 48'("esle"), 48'("tni"), 48'("nruter"), 48'("diov"), 48'("elihw")
    };
    localparam logic [CNT_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd2, 5'd4, 5'd3, 5'd6, 5'd4, 5'd5
    };

    // Scanner states.
    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_DIGITS    = 4'd1,
        ST_LETTERS   = 4'd2,
        ST_GT        = 4'd3,
        ST_LT        = 4'd4,
        ST_BANG      = 4'd5,
        ST_EQ        = 4'd6,
        ST_SLASH     = 4'd7,
        ST_COMM      = 4'd8,
        ST_COMM_STAR = 4'd9
    } scan_state_t;

    // Input word.
    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
    } lex_in_t;

    // Result word.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [4:0]  lexeme_length;
        logic [63:0] lexeme_word0;
        logic [63:0] lexeme_word1;
        logic [63:0] lexeme_word2;
        logic [63:0] lexeme_word3;
        logic        truncated;
        logic        last;
    } lex_out_t;

    // Token record passed from front to back; keywords are not yet resolved.
    typedef struct packed {
        logic [4:0]       kind;
        logic             is_word;
        logic [CNT_W-1:0] length;
        logic [LEX_W-1:0] lexeme;
        logic             truncated;
        logic             last;
    } tok_rec_t;

    // Front status seen by the top level.
    typedef struct packed {
        logic             pend2;
        logic [CNT_W-1:0] lexeme_count;
    } front_stat_t;

    // Token for a character that stands alone; ERROR for anything unknown.
    function automatic logic [4:0] single_kind(input logic [7:0] ch);
        logic [4:0] k;
        unique case (ch)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_TIMES;
            ";":     k = TK_SEMI;
            ",":     k = TK_COMMA;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "[":     k = TK_LBRACK;
            "]":     k = TK_RBRACK;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            default: k = TK_ERROR;
        endcase
        return k;
    endfunction

    // Keyword lookup on the first six lexeme bytes; ID when nothing matches.
    function automatic logic [4:0] kw_kind(input logic [CNT_W-1:0] len,
                                           input logic [47:0] text);
        logic [4:0] k;
        k = TK_ID;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
                k = TK_IF + 5'(i);
            end
        end
        return k;
    endfunction

endpackage

@@ src/c_minus_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer
// Scanner for the C-minus language: one character or end-of-input mark in
// per word, one token record out per word.
// ----------------------------------------------------------------------------
// The lexer takes one input word per clock cycle while s_ready is high. An
// input word that both ends a pending token and is itself a one-character
// token, or an end of input that closes a pending token, yields two tokens and
// holds off input while the second waits, since the front end pushes one token
// per cycle into the queue. A token passes the token queue and the output
// register; the front end, a two-entry token queue and the output register
// let the input and result sides stall independently.
module c_minus_lexer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  c_lex_pkg::lex_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output c_lex_pkg::lex_out_t m_data
);
    import c_lex_pkg::*;

    logic        push_valid, push_ready, pop_valid, pop_ready;
    tok_rec_t    push_data, pop_data;
    front_stat_t fstat;

    // Scanner automaton and lexeme storage.
    c_lex_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .stat       (fstat)
    );

    // Token queue.
    c_lex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Keyword resolution and output register.
    c_lex_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Input is held off while a second token waits for the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.pend2 |-> !s_ready)
        else $error("input accepted while a second token is held");

    // The lexeme count never passes the kept length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.lexeme_count <= CNT_W'(LEXEME_CHARS))
        else $error("lexeme count beyond kept length");

    // ENDFILE carries an empty lexeme and closes its input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.token_kind == TK_ENDFILE) |->
            (m_data.lexeme_length == '0 && m_data.lexeme_word0 == '0 && m_data.last))
        else $error("malformed ENDFILE token");

    // The byte past the kept length is always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.lexeme_word3[63:56] == 8'h00))
        else $error("lexeme byte beyond kept length is set");

endmodule

@@ src/c_lex_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer front end
// Accepts characters, runs the scanner automaton, keeps the lexeme bytes
// and pushes finished tokens into the token queue.
// ----------------------------------------------------------------------------
module c_lex_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  c_lex_pkg::lex_in_t     s_data,
    output logic                   push_valid,
    output c_lex_pkg::tok_rec_t    push_data,
    input  logic                   push_ready,
    output c_lex_pkg::front_stat_t stat
);
    import c_lex_pkg::*;

    scan_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [7:0]       store_reg [LEXEME_CHARS];

    // Second token of an item, held until the queue takes it.
    logic             pend_valid_reg;
    logic             pend_eof_reg;
    logic [4:0]       pend_kind_reg;
    logic [7:0]       pend_byte_reg;

    logic [7:0]  ch;
    logic        accept;
    logic        is_dig, is_let, ia_blank, ia_emit;
    scan_state_t ia_state;
    logic [4:0]  ia_kind;
    logic        pk_valid, pk_word;
    logic [4:0]  pk_kind, two_kind;
    logic        t1_valid, t1_word, t1_append, t1_eof;
    logic [4:0]  t1_kind;
    logic        t2_valid, t2_eof;
    logic [4:0]  t2_kind;
    logic        lx_clear, lx_keep, lx_start;
    logic        end_tok, from_idle, append_ok;
    tok_rec_t    tok1, tok2;

    assign ch       = s_data.char_code;
    assign s_ready  = !pend_valid_reg && push_ready;
    assign accept   = s_valid && s_ready;

    // Character classes and the start-state move for the current character.
    always_comb begin
        is_dig   = (ch >= "0") && (ch <= "9");
        is_let   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
        ia_blank = (ch == " ") || (ch == 8'h09) || (ch == 8'h0A);
        ia_kind  = single_kind(ch);
        ia_emit  = 1'b0;
        priority if (ia_blank) begin
            ia_state = ST_IDLE;
        end else if (is_dig) begin
            ia_state = ST_DIGITS;
        end else if (is_let) begin
            ia_state = ST_LETTERS;
        end else if (ch == "<") begin
            ia_state = ST_LT;
        end else if (ch == ">") begin
            ia_state = ST_GT;
        end else if (ch == "=") begin
            ia_state = ST_EQ;
        end else if (ch == "!") begin
            ia_state = ST_BANG;
        end else if (ch == "/") begin
            ia_state = ST_SLASH;
        end else begin
            ia_state = ST_IDLE;
            ia_emit  = 1'b1;
        end
    end

    // Token left pending by the current state when lookahead ends it.
    always_comb begin
        pk_valid = 1'b1;
        pk_word  = 1'b0;
        two_kind = TK_EQ;
        unique case (state_reg)
            ST_DIGITS:  pk_kind = TK_NUM;
            ST_LETTERS: begin
                pk_kind = TK_ID;
                pk_word = 1'b1;
            end
            ST_GT: begin
                pk_kind  = TK_GT;
                two_kind = TK_GE;
            end
            ST_LT: begin
                pk_kind  = TK_LT;
                two_kind = TK_LE;
            end
            ST_BANG: begin
                pk_kind  = TK_ERROR;
                two_kind = TK_NE;
            end
            ST_EQ:      pk_kind = TK_ASSIGN;
            ST_SLASH:   pk_kind = TK_DIV;
            default: begin
                pk_kind  = TK_ENDFILE;
                pk_valid = 1'b0;
            end
        endcase
    end

    // Next scan state.
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            if (s_data.op == OP_EOF) begin
                state_next = ST_IDLE;
            end else begin
                unique case (state_reg)
                    ST_DIGITS:  state_next = is_dig ? ST_DIGITS : ia_state;
                    ST_LETTERS: state_next = is_let ? ST_LETTERS : ia_state;
                    ST_GT, ST_LT, ST_BANG, ST_EQ: begin
                        state_next = (ch == "=") ? ST_IDLE : ia_state;
                    end
                    ST_SLASH:   state_next = (ch == "*") ? ST_COMM : ia_state;
                    ST_COMM:    state_next = (ch == "*") ? ST_COMM_STAR : ST_COMM;
                    ST_COMM_STAR: begin
                        if (ch == "/") begin
                            state_next = ST_IDLE;
                        end else if (ch == "*") begin
                            state_next = ST_COMM_STAR;
                        end else begin
                            state_next = ST_COMM;
                        end
                    end
                    default:    state_next = ia_state;
                endcase
            end
        end
    end

    // Token and lexeme actions of the automaton.
    always_comb begin
        t1_valid  = 1'b0;
        t1_word   = 1'b0;
        t1_append = 1'b0;
        t1_eof    = 1'b0;
        t1_kind   = TK_ENDFILE;
        t2_valid  = 1'b0;
        t2_eof    = 1'b0;
        t2_kind   = TK_ENDFILE;
        lx_clear  = 1'b0;
        lx_keep   = 1'b0;
        lx_start  = 1'b0;
        end_tok   = 1'b0;
        from_idle = 1'b0;
        if (s_data.op == OP_EOF) begin
            // Finish a pending token, then ENDFILE with an empty lexeme.
            t1_valid = 1'b1;
            lx_clear = 1'b1;
            if (pk_valid) begin
                t1_kind  = pk_kind;
                t1_word  = pk_word;
                t2_valid = 1'b1;
                t2_eof   = 1'b1;
            end else begin
                t1_eof = 1'b1;
            end
        end else begin
            unique case (state_reg)
                ST_DIGITS: begin
                    lx_keep = is_dig;
                    end_tok = !is_dig;
                end
                ST_LETTERS: begin
                    lx_keep = is_let;
                    end_tok = !is_let;
                end
                ST_GT, ST_LT, ST_BANG, ST_EQ: begin
                    if (ch == "=") begin
                        t1_valid  = 1'b1;
                        t1_kind   = two_kind;
                        t1_append = 1'b1;
                        lx_clear  = 1'b1;
                    end else begin
                        end_tok = 1'b1;
                    end
                end
                ST_SLASH:     end_tok = (ch != "*");
                ST_COMM:      lx_clear = 1'b0;
                ST_COMM_STAR: lx_clear = (ch == "/");
                default:      from_idle = 1'b1;
            endcase

            // Lookahead ended a token; the character starts over from idle.
            if (end_tok) begin
                t1_valid = 1'b1;
                t1_kind  = pk_kind;
                t1_word  = pk_word;
                lx_clear = 1'b1;
                if (ia_emit) begin
                    t2_valid = 1'b1;
                    t2_kind  = ia_kind;
                end else if (!ia_blank) begin
                    lx_start = 1'b1;
                end
            end

            if (from_idle) begin
                if (ia_emit) begin
                    t1_valid  = 1'b1;
                    t1_kind   = ia_kind;
                    t1_append = 1'b1;
                    lx_clear  = 1'b1;
                end else if (!ia_blank) begin
                    lx_start = 1'b1;
                end
            end
        end
    end

    // Assemble the first token from the stored lexeme and the character.
    always_comb begin
        append_ok      = t1_append && (count_reg < CNT_W'(LEXEME_CHARS));
        tok1           = '0;
        tok1.kind      = t1_kind;
        tok1.is_word   = t1_word;
        tok1.last      = !t2_valid;
        if (!t1_eof) begin
            tok1.length    = count_reg + CNT_W'(append_ok);
            tok1.truncated = ovf_reg || (t1_append && !append_ok);
            for (int i = 0; i < LEXEME_CHARS; i++) begin
                if (CNT_W'(i) < count_reg) begin
                    tok1.lexeme[i*8 +: 8] = store_reg[i];
                end else if (append_ok && CNT_W'(i) == count_reg) begin
                    tok1.lexeme[i*8 +: 8] = ch;
                end
            end
        end
    end

    // Held second token: a lone symbol or ENDFILE.
    always_comb begin
        tok2           = '0;
        tok2.kind      = pend_kind_reg;
        tok2.last      = 1'b1;
        if (!pend_eof_reg) begin
            tok2.length       = CNT_W'(1);
            tok2.lexeme[7:0]  = pend_byte_reg;
        end
    end

    // Queue push: the held token goes first and blocks new input.
    always_comb begin
        if (pend_valid_reg) begin
            push_valid = 1'b1;
            push_data  = tok2;
        end else begin
            push_valid = accept && t1_valid;
            push_data  = tok1;
        end
    end

    assign stat.pend2        = pend_valid_reg;
    assign stat.lexeme_count = count_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pend_valid_reg && push_ready) begin
                pend_valid_reg <= 1'b0;
            end else if (accept && t2_valid) begin
                pend_valid_reg <= 1'b1;
            end
            if (accept) begin
                if (lx_start) begin
                    count_reg <= CNT_W'(1);
                    ovf_reg   <= 1'b0;
                end else if (lx_clear) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end else if (lx_keep) begin
                    if (count_reg < CNT_W'(LEXEME_CHARS)) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Lexeme bytes and the held token payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (lx_start) begin
                store_reg[0] <= ch;
            end else if (lx_keep && (count_reg < CNT_W'(LEXEME_CHARS))) begin
                store_reg[count_reg] <= ch;
            end
            if (t2_valid) begin
                pend_eof_reg  <= t2_eof;
                pend_kind_reg <= t2_kind;
                pend_byte_reg <= ch;
            end
        end
    end

endmodule

@@ src/c_lex_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer token queue
// Short first-in first-out queue of token records between the front end
// and the back end.
// ----------------------------------------------------------------------------
module c_lex_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  c_lex_pkg::tok_rec_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output c_lex_pkg::tok_rec_t pop_data
);
    import c_lex_pkg::*;

    tok_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/c_lex_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer back end
// Resolves keywords on identifier tokens and holds the result word in the
// output register.
// ----------------------------------------------------------------------------
module c_lex_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  c_lex_pkg::tok_rec_t  pop_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output c_lex_pkg::lex_out_t  m_data
);
    import c_lex_pkg::*;

    logic     m_valid_reg;
    lex_out_t m_data_reg, m_data_next;

    assign pop_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Keyword check: a truncated identifier is never a keyword.
    always_comb begin
        m_data_next.token_kind = (pop_data.is_word && !pop_data.truncated)
                               ? kw_kind(pop_data.length, pop_data.lexeme[47:0])
                               : pop_data.kind;
        m_data_next.lexeme_length = pop_data.length;
        m_data_next.lexeme_word0  = pop_data.lexeme[63:0];
        m_data_next.lexeme_word1  = pop_data.lexeme[127:64];
        m_data_next.lexeme_word2  = pop_data.lexeme[191:128];
        m_data_next.lexeme_word3  = pop_data.lexeme[255:192];
        m_data_next.truncated     = pop_data.truncated;
        m_data_next.last          = pop_data.last;
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            m_valid_reg <= pop_valid;
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ tb/sv/tb_c_minus_lexer_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer checker
// Watches the character and token channels of the lexer. It runs its own
// scanner on every accepted input word to build the expected tokens,
// and compares every accepted token word with the oldest expected one,
// field by field.
// ----------------------------------------------------------------------------
module tb_c_minus_lexer_chk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  c_lex_pkg::lex_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  c_lex_pkg::lex_out_t m_data,
    output int unsigned         pending_tokens,
    output int unsigned         mismatch_count
);
    import c_lex_pkg::*;

    // Keyword spellings in token code order, starting at TK_IF.
    string keyword_text [6] = '{"if", "else", "int", "return", "void", "while"};

    // Scanner state of the predictor.
    scan_state_t scan_st;
    logic [7:0]  lex_buf [LEXEME_CHARS];
    logic [4:0]  lex_cnt;
    logic        lex_ovf;

    // Tokens caused by the current character word, and all tokens still due.
    lex_out_t    word_toks [2];
    int          word_ntok;
    lex_out_t    token_q [$];

    function automatic logic is_digit(logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    // Bytes beyond the kept length are dropped and flagged.
    function automatic void keep_byte(logic [7:0] ch);
        if (lex_cnt < LEXEME_CHARS) begin
            lex_buf[lex_cnt] = ch;
            lex_cnt++;
        end else begin
            lex_ovf = 1'b1;
        end
    endfunction

    // A truncated word is always an identifier.
    function automatic logic [4:0] word_token_kind();
        logic hit;
        if (lex_ovf) return TK_ID;
        for (int k = 0; k < 6; k++) begin
            if (keyword_text[k].len() == lex_cnt) begin
                hit = 1'b1;
                for (int i = 0; i < keyword_text[k].len(); i++) begin
                    if (keyword_text[k][i] != lex_buf[i]) hit = 1'b0;
                end
                if (hit) return TK_IF + 5'(k);
            end
        end
        return TK_ID;
    endfunction

    function automatic logic [4:0] lone_char_kind(logic [7:0] ch);
        case (ch)
            "+":     return TK_PLUS;
            "-":     return TK_MINUS;
            "*":     return TK_TIMES;
            ";":     return TK_SEMI;
            ",":     return TK_COMMA;
            "(":     return TK_LPAREN;
            ")":     return TK_RPAREN;
            "[":     return TK_LBRACK;
            "]":     return TK_RBRACK;
            "{":     return TK_LBRACE;
            "}":     return TK_RBRACE;
            default: return TK_ERROR;
        endcase
    endfunction

    // Token that a non-matching character closes; -1 when nothing is open.
    function automatic int open_token_kind();
        case (scan_st)
            ST_DIGITS:  return TK_NUM;
            ST_LETTERS: return word_token_kind();
            ST_GT:      return TK_GT;
            ST_LT:      return TK_LT;
            ST_BANG:    return TK_ERROR;
            ST_EQ:      return TK_ASSIGN;
            ST_SLASH:   return TK_DIV;
            default:    return -1;
        endcase
    endfunction

    // Record a token with the current lexeme, then start over.
    function automatic void emit_token(logic [4:0] kind);
        logic [255:0] bytes;
        lex_out_t     tok;
        if (word_ntok < 2) begin
            bytes = '0;
            for (int i = 0; i < lex_cnt; i++) bytes[i*8 +: 8] = lex_buf[i];
            tok               = '0;
            tok.token_kind    = kind;
            tok.lexeme_length = lex_cnt;
            tok.lexeme_word0  = bytes[63:0];
            tok.lexeme_word1  = bytes[127:64];
            tok.lexeme_word2  = bytes[191:128];
            tok.lexeme_word3  = bytes[255:192];
            tok.truncated     = lex_ovf;
            word_toks[word_ntok] = tok;
            word_ntok++;
            lex_cnt = '0;
            lex_ovf = 1'b0;
            scan_st = ST_IDLE;
        end
    endfunction

    // First character of a token, seen in the start state.
    function automatic void start_token(logic [7:0] ch);
        if (ch == " " || ch == "\t" || ch == "\n") return;
        keep_byte(ch);
        if (is_digit(ch))       scan_st = ST_DIGITS;
        else if (is_letter(ch)) scan_st = ST_LETTERS;
        else if (ch == "<")     scan_st = ST_LT;
        else if (ch == ">")     scan_st = ST_GT;
        else if (ch == "=")     scan_st = ST_EQ;
        else if (ch == "!")     scan_st = ST_BANG;
        else if (ch == "/")     scan_st = ST_SLASH;
        else                    emit_token(lone_char_kind(ch));
    endfunction

    // One character through the automaton. A character that closes an open
    // token is scanned again from the start state.
    function automatic void scan_char(logic [7:0] ch);
        logic [4:0] two_kind;
        case (scan_st)
            ST_DIGITS: begin
                if (is_digit(ch)) begin
                    keep_byte(ch);
                    return;
                end
            end
            ST_LETTERS: begin
                if (is_letter(ch)) begin
                    keep_byte(ch);
                    return;
                end
            end
            ST_GT, ST_LT, ST_BANG, ST_EQ: begin
                if (ch == "=") begin
                    two_kind = (scan_st == ST_GT) ? TK_GE :
                               (scan_st == ST_LT) ? TK_LE :
                               (scan_st == ST_BANG) ? TK_NE : TK_EQ;
                    keep_byte(ch);
                    emit_token(two_kind);
                    return;
                end
            end
            ST_SLASH: begin
                if (ch == "*") begin
                    scan_st = ST_COMM;
                    return;
                end
            end
            ST_COMM: begin
                if (ch == "*") scan_st = ST_COMM_STAR;
                return;
            end
            ST_COMM_STAR: begin
                if (ch == "/") begin
                    lex_cnt = '0;
                    lex_ovf = 1'b0;
                    scan_st = ST_IDLE;
                end else if (ch != "*") begin
                    scan_st = ST_COMM;
                end
                return;
            end
            default: begin
                scan_st = ST_IDLE;
                start_token(ch);
                return;
            end
        endcase
        emit_token(5'(open_token_kind()));
        start_token(ch);
    endfunction

    // Expected tokens of one accepted input word; the final one carries last.
    function automatic void predict_word(lex_in_t w);
        int k;
        word_ntok = 0;
        if (w.op == OP_EOF) begin
            k = open_token_kind();
            if (k >= 0) emit_token(5'(k));
            lex_cnt = '0;
            lex_ovf = 1'b0;
            emit_token(TK_ENDFILE);
        end else begin
            scan_char(w.char_code);
        end
        for (int i = 0; i < word_ntok; i++) begin
            if (i == word_ntok - 1) word_toks[i].last = 1'b1;
            token_q.push_back(word_toks[i]);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: token mismatch on %s: got %0h, expected %0h",
                 $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_token(input lex_out_t got, input lex_out_t want);
        if (got.token_kind != want.token_kind)
            report_mismatch("token_kind", 64'(got.token_kind), 64'(want.token_kind));
        if (got.lexeme_length != want.lexeme_length)
            report_mismatch("lexeme_length", 64'(got.lexeme_length),
                            64'(want.lexeme_length));
        if (got.lexeme_word0 != want.lexeme_word0)
            report_mismatch("lexeme_word0", got.lexeme_word0, want.lexeme_word0);
        if (got.lexeme_word1 != want.lexeme_word1)
            report_mismatch("lexeme_word1", got.lexeme_word1, want.lexeme_word1);
        if (got.lexeme_word2 != want.lexeme_word2)
            report_mismatch("lexeme_word2", got.lexeme_word2, want.lexeme_word2);
        if (got.lexeme_word3 != want.lexeme_word3)
            report_mismatch("lexeme_word3", got.lexeme_word3, want.lexeme_word3);
        if (got.truncated != want.truncated)
            report_mismatch("truncated", 64'(got.truncated), 64'(want.truncated));
        if (got.last != want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask

    // Token words are checked before the character word of the same edge is
    // predicted; a token never stems from a word accepted at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_st = ST_IDLE;
            lex_cnt = '0;
            lex_ovf = 1'b0;
            token_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    report_mismatch("token with none expected", 64'(m_data.token_kind),
                                    64'(0));
                end else begin
                    check_token(m_data, token_q.pop_front());
                end
            end
            if (s_valid && s_ready) predict_word(s_data);
        end
        pending_tokens <= token_q.size();
    end

endmodule

@@ tb/sv/tb_c_minus_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-minus lexer testbench
// Feeds the lexer a short directed text with the odd cases first, then
// random C-minus fragments mixed with noise bytes and end-of-input marks,
// with bursty input and a stalling token receiver. The checker beside the
// lexer predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_c_minus_lexer;
    import c_lex_pkg::*;

    localparam int          RANDOM_ITEMS = 500;
    localparam int          PAUSE_EVERY  = 150;
    localparam int unsigned QUIET_LIMIT  = 200;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lex_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lex_out_t m_data;

    int unsigned pending_tokens;
    int unsigned mismatch_count;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left   = 0;
    int unsigned ready_run    = 0;
    int unsigned stall_run    = 0;

    lex_in_t stim_q [$];

    string op_text [20] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=",
                            "=", ";", ",", "(", ")", "[", "]", "{", "}", "!"};
    string kw_text [6]  = '{"if", "else", "int", "return", "void", "while"};

    c_minus_lexer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tb_c_minus_lexer_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .pending_tokens (pending_tokens),
        .mismatch_count (mismatch_count)
    );

    always #5 aclk = ~aclk;

    // Receiver: runs of ready cycles broken by stalls of random length.
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            m_ready   <= 1'b1;
            ready_run <= ready_run - 1;
        end else if (stall_run > 0) begin
            m_ready   <= 1'b0;
            stall_run <= stall_run - 1;
        end else begin
            m_ready   <= 1'b0;
            ready_run <= $urandom_range(1, 30);
            stall_run <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic push_byte(input logic [7:0] ch);
        stim_q.push_back('{OP_CHAR, ch});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_eof();
        stim_q.push_back('{OP_EOF, 8'($urandom_range(0, 255))});
    endtask

    // Sender: bursts of random length, each preceded by a random gap or none.
    task automatic send_item(input lex_in_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_queued();
        while (stim_q.size() > 0) send_item(stim_q.pop_front());
    endtask

    // Hold the input until every expected token has been taken.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens != 0) @(posedge aclk);
    endtask

    // One random fragment of source text; every queued word counts.
    task automatic add_fragment(output int unsigned counted);
        int unsigned pick;
        int unsigned n;
        int unsigned before_size;
        before_size = stim_q.size();
        pick        = $urandom_range(0, 99);
        if (pick < 20) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 7);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) push_byte(8'("A" + $urandom_range(0, 25)));
                else push_byte(8'("a" + $urandom_range(0, 25)));
            end
        end else if (pick < 30) begin
            push_text(kw_text[$urandom_range(0, 5)]);
        end else if (pick < 45) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 5);
            for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 70) begin
            push_text(op_text[$urandom_range(0, 19)]);
        end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0:       push_byte(" ");
                    1:       push_byte("\t");
                    default: push_byte("\n");
                endcase
            end
        end else if (pick < 85) begin
            push_text("/*");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       push_byte("*");
                    1:       push_byte("/");
                    default: push_byte(8'($urandom_range(0, 255)));
                endcase
            end
            push_text("*/");
        end else if (pick < 97) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_eof();
        end
        counted = stim_q.size() - before_size;
    endtask

    initial begin
        int unsigned sent;
        int unsigned next_pause;
        int unsigned counted;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Keyword closed by a lone symbol, two-character and lone bang,
        // pending word at end of input, comment closed after extra stars,
        // bytes outside the alphabet, end of input inside a comment, and a
        // pending operator closed by end of input.
        push_text("while(");
        push_text("!=");
        push_text("!a");
        push_eof();
        push_text("/***/");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h0D);
        push_byte(8'h80);
        push_text("/*");
        push_eof();
        push_text("9<");
        push_eof();
        send_queued();

        // Random source text, with a full drain now and then.
        sent       = 0;
        next_pause = PAUSE_EVERY;
        while (sent < RANDOM_ITEMS) begin
            add_fragment(counted);
            send_queued();
            sent += counted;
            if (sent >= next_pause) begin
                hold_until_drained();
                next_pause += PAUSE_EVERY;
            end
        end

        // Drain, then allow for the pipeline before the verdict.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
